// ===== rtl/core/ucpi_pkg.sv =====
// shared types and constants for the unique color palette indexer
// no dependencies; compiled first

package ucpi_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 16;
   localparam int CHAN_W                = 8;
   localparam int COLOR_W               = 4 * CHAN_W;
   localparam int LAYER_W               = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      RES_HIT,
      RES_NEW,
      RES_TRANSPARENT,
      RES_OVERFLOW
   } res_kind_type;

   typedef struct packed {
      logic         load;
      logic         read;
      logic         step;
      logic         append;
      logic         set_result;
      res_kind_type res_kind;
      logic         emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic transparent;
      logic scan_end;
      logic full;
      logic match;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/core/ucpi_channels.sv =====
// valid/ready channel interfaces for pixel requests and palette responses
// depends on ucpi_pkg

interface ucpi_req_if;
   logic                        valid;
   logic                        ready;
   logic                        first_of_image;
   logic [ucpi_pkg::CHAN_W-1:0] red;
   logic [ucpi_pkg::CHAN_W-1:0] green;
   logic [ucpi_pkg::CHAN_W-1:0] blue;
   logic [ucpi_pkg::CHAN_W-1:0] alpha;

   modport source (output valid, first_of_image, red, green, blue, alpha, input ready);
   modport sink (input valid, first_of_image, red, green, blue, alpha, output ready);
endinterface

interface ucpi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ucpi_pkg::LAYER_W-1:0] layer_index;
   logic                         new_color;
   logic                         transparent;
   logic                         palette_overflow;

   modport source (output valid, layer_index, new_color, transparent, palette_overflow,
                   input ready);
   modport sink (input valid, layer_index, new_color, transparent, palette_overflow,
                 output ready);
endinterface

// ===== rtl/core/unique_color_palette_indexer.sv =====
// Unique color palette indexer. Each accepted pixel transaction gives exactly one
// response transaction. The palette lives in a memory with one write port and one
// registered read port that is walked one entry at a time (read, then compare); a
// transparent pixel skips the walk and a hit ends it. A finished response waits in
// the output register, and the next pixel is accepted while it waits. No clearing
// pass after reset: a fill count marks the valid entries.
// depends on ucpi_pkg, ucpi_channels, ucpi_ctl and ucpi_dp

module unique_color_palette_indexer #(
   parameter int PALETTE_DEPTH = ucpi_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ucpi_req_if.sink   req_ch,
   ucpi_rsp_if.source rsp_ch
);

   ucpi_pkg::ctl_cmd_type   cmd;
   ucpi_pkg::dp_status_type status;
   logic                    req_ready;

   assign req_ch.ready = req_ready;

   ucpi_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   ucpi_dp #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// ===== rtl/core/ucpi_ctl.sv =====
// controller state machine: accepts a pixel, walks the palette, issues the response
// depends on ucpi_pkg

module ucpi_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  ucpi_pkg::dp_status_type status,
   output ucpi_pkg::ctl_cmd_type   cmd,
   output logic                    req_ready
);

   ucpi_pkg::ctl_state_type state_ff;
   ucpi_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ucpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ucpi_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               state_in = ucpi_pkg::ST_CHECK;
            end
         end
         ucpi_pkg::ST_CHECK: begin
            if (status.transparent || status.scan_end) begin
               state_in = ucpi_pkg::ST_EMIT;
            end else begin
               state_in = ucpi_pkg::ST_COMPARE;
            end
         end
         ucpi_pkg::ST_COMPARE: begin
            if (status.match) begin
               state_in = ucpi_pkg::ST_EMIT;
            end else begin
               state_in = ucpi_pkg::ST_CHECK;
            end
         end
         ucpi_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ucpi_pkg::ST_IDLE;
            end
         end
         default: state_in = ucpi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ucpi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = status.req_valid;
         end
         ucpi_pkg::ST_CHECK: begin
            priority if (status.transparent) begin
               cmd.set_result = 1'b1;
               cmd.res_kind   = ucpi_pkg::RES_TRANSPARENT;
            end else if (status.scan_end && status.full) begin
               cmd.set_result = 1'b1;
               cmd.res_kind   = ucpi_pkg::RES_OVERFLOW;
            end else if (status.scan_end) begin
               cmd.set_result = 1'b1;
               cmd.res_kind   = ucpi_pkg::RES_NEW;
               cmd.append     = 1'b1;
            end else begin
               cmd.read = 1'b1;
            end
         end
         ucpi_pkg::ST_COMPARE: begin
            if (status.match) begin
               cmd.set_result = 1'b1;
               cmd.res_kind   = ucpi_pkg::RES_HIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ucpi_pkg::ST_EMIT: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/ucpi_dp.sv =====
// datapath: pixel register, palette memory, scan pointer, fill count, response register
// depends on ucpi_pkg and the channel interfaces in ucpi_channels

module ucpi_dp #(
   parameter int PALETTE_DEPTH = ucpi_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   ucpi_req_if.sink                req_ch,
   ucpi_rsp_if.source              rsp_ch,
   input  ucpi_pkg::ctl_cmd_type   cmd,
   output ucpi_pkg::dp_status_type status
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

   logic [ucpi_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [ucpi_pkg::COLOR_W-1:0] rd_ff;

   logic [ucpi_pkg::COLOR_W-1:0] color_ff;
   logic                         transp_ff;
   logic [CNT_W-1:0]             used_ff;
   logic [CNT_W-1:0]             used_in;
   logic [CNT_W-1:0]             k_ff;
   logic [CNT_W-1:0]             k_in;

   logic [ucpi_pkg::LAYER_W-1:0] res_layer_ff;
   logic                         res_new_ff;
   logic                         res_transp_ff;
   logic                         res_over_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [ucpi_pkg::LAYER_W-1:0] rsp_layer_ff;
   logic                         rsp_new_ff;
   logic                         rsp_transp_ff;
   logic                         rsp_over_ff;

   logic [31:0]                  k_wide;
   logic [31:0]                  used_wide;
   logic                         rsp_free;

   assign k_wide    = 32'(k_ff);
   assign used_wide = 32'(used_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   assign status.req_valid   = req_ch.valid;
   assign status.transparent = transp_ff;
   assign status.scan_end    = (k_ff == used_ff);
   assign status.full        = (used_ff == DEPTH_CNT);
   assign status.match       = (rd_ff == color_ff);
   assign status.rsp_free    = rsp_free;

   // palette memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[used_ff[IDX_W-1:0]] <= color_ff;
      end
      if (cmd.read) begin
         rd_ff <= mem[k_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         color_ff  <= {req_ch.red, req_ch.green, req_ch.blue, req_ch.alpha};
         transp_ff <= (req_ch.alpha == '0);
      end
   end

   always_comb begin
      used_in = used_ff;
      k_in    = k_ff;
      if (cmd.load) begin
         k_in = '0;
         if (req_ch.first_of_image) begin
            used_in = '0;
         end
      end
      if (cmd.step) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (cmd.append) begin
         used_in = used_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         k_ff    <= '0;
      end else begin
         used_ff <= used_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         res_layer_ff  <= '0;
         res_new_ff    <= 1'b0;
         res_transp_ff <= 1'b0;
         res_over_ff   <= 1'b0;
         unique case (cmd.res_kind)
            ucpi_pkg::RES_HIT:         res_layer_ff  <= k_wide[ucpi_pkg::LAYER_W-1:0];
            ucpi_pkg::RES_NEW: begin
               res_layer_ff <= used_wide[ucpi_pkg::LAYER_W-1:0];
               res_new_ff   <= 1'b1;
            end
            ucpi_pkg::RES_TRANSPARENT: res_transp_ff <= 1'b1;
            ucpi_pkg::RES_OVERFLOW:    res_over_ff   <= 1'b1;
            default:                   res_layer_ff  <= '0;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_layer_ff  <= res_layer_ff;
         rsp_new_ff    <= res_new_ff;
         rsp_transp_ff <= res_transp_ff;
         rsp_over_ff   <= res_over_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.layer_index      = rsp_layer_ff;
   assign rsp_ch.new_color        = rsp_new_ff;
   assign rsp_ch.transparent      = rsp_transp_ff;
   assign rsp_ch.palette_overflow = rsp_over_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH_CNT)
      else $error("palette fill count beyond depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= used_ff)
      else $error("scan pointer past fill count");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (used_ff < DEPTH_CNT))
      else $error("append into a full palette");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rsp_free)
      else $error("response overwritten before transaction");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> (k_ff < used_ff))
      else $error("read of an unwritten palette entry");
`endif

endmodule

// ===== dv/ucpi_palette_checker.sv =====
// watches the pixel and palette-index transactions of the unique color palette indexer,
// predicts each response from its own palette copy and compares field by field
// depends on ucpi_pkg and ucpi_channels

module ucpi_palette_checker #(
   parameter int PALETTE_DEPTH = ucpi_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   ucpi_req_if  pixel_ch,
   ucpi_rsp_if  index_ch,
   output int   mismatch_count,
   output int   pending_count,
   output int   hit_count,
   output int   new_count,
   output int   transparent_count,
   output int   overflow_count
);
   import ucpi_pkg::*;

   typedef struct packed {
      logic [LAYER_W-1:0] layer_index;
      logic               new_color;
      logic               transparent;
      logic               palette_overflow;
   } palette_answer_type;

   logic [COLOR_W-1:0] palette_colors [PALETTE_DEPTH];
   int                 colors_used;
   palette_answer_type answers_due [$];

   function automatic palette_answer_type lookup_palette(input logic first,
                                                         input logic [COLOR_W-1:0] rgba);
      palette_answer_type answer;
      int                 position;
      bit                 found;
      answer   = '0;
      position = 0;
      found    = 0;
      if (first)
         colors_used = 0;
      if (rgba[CHAN_W-1:0] == '0) begin
         answer.transparent = 1'b1;
         transparent_count++;
      end else begin
         for (int k = 0; k < colors_used; k++) begin
            if (!found && palette_colors[k] == rgba) begin
               found    = 1;
               position = k;
            end
         end
         if (found) begin
            hit_count++;
         end else if (colors_used < PALETTE_DEPTH) begin
            position                    = colors_used;
            palette_colors[colors_used] = rgba;
            colors_used++;
            answer.new_color = 1'b1;
            new_count++;
         end else begin
            answer.palette_overflow = 1'b1;
            overflow_count++;
         end
      end
      answer.layer_index = LAYER_W'(position);
      return answer;
   endfunction

   always @(posedge clock) begin
      palette_answer_type due;
      if (reset) begin
         answers_due.delete();
         colors_used = 0;
      end else begin
         if (index_ch.valid && index_ch.ready) begin
            if (answers_due.size() == 0) begin
               $error("response transaction with no pixel outstanding");
               mismatch_count++;
            end else begin
               due = answers_due.pop_front();
               if (index_ch.layer_index !== due.layer_index) begin
                  $error("layer_index expected %0d, actual %0d",
                         due.layer_index, index_ch.layer_index);
                  mismatch_count++;
               end
               if (index_ch.new_color !== due.new_color) begin
                  $error("new_color expected %0b, actual %0b",
                         due.new_color, index_ch.new_color);
                  mismatch_count++;
               end
               if (index_ch.transparent !== due.transparent) begin
                  $error("transparent expected %0b, actual %0b",
                         due.transparent, index_ch.transparent);
                  mismatch_count++;
               end
               if (index_ch.palette_overflow !== due.palette_overflow) begin
                  $error("palette_overflow expected %0b, actual %0b",
                         due.palette_overflow, index_ch.palette_overflow);
                  mismatch_count++;
               end
            end
         end
         if (pixel_ch.valid && pixel_ch.ready)
            answers_due = {answers_due, lookup_palette(pixel_ch.first_of_image,
               {pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.alpha})};
      end
      pending_count <= answers_due.size();
   end

endmodule

// ===== dv/unique_color_palette_indexer_test.sv =====
// top of the unique color palette indexer regression: clock, reset, pixel stimulus,
// response flow control and verdict
// depends on ucpi_pkg, ucpi_channels, unique_color_palette_indexer and ucpi_palette_checker

module unique_color_palette_indexer_test;
   import ucpi_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int DRAIN_LIMIT     = 20000;

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_idle_pct;
   int   pressure_requests;
   int   pressure_served;
   int   pixels_sent;
   int   images_sent;
   int   mismatch_count;
   int   pending_count;
   int   hit_count;
   int   new_count;
   int   transparent_count;
   int   overflow_count;

   ucpi_req_if pixel_ch ();
   ucpi_rsp_if index_ch ();

   unique_color_palette_indexer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (pixel_ch),
      .rsp_ch (index_ch)
   );

   ucpi_palette_checker palette_checker (
      .clock             (clock),
      .reset             (reset),
      .pixel_ch          (pixel_ch),
      .index_ch          (index_ch),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .hit_count         (hit_count),
      .new_count         (new_count),
      .transparent_count (transparent_count),
      .overflow_count    (overflow_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #12000000;
      $display("unique_color_palette_indexer regression: fail");
      $finish;
   end

   task automatic send_pixel(input logic first, input logic [COLOR_W-1:0] rgba);
      while ($urandom_range(99) < sender_idle_pct) begin
         pixel_ch.valid <= 1'b0;
         @(negedge clock);
      end
      pixel_ch.valid          <= 1'b1;
      pixel_ch.first_of_image <= first;
      pixel_ch.red            <= rgba[3*CHAN_W +: CHAN_W];
      pixel_ch.green          <= rgba[2*CHAN_W +: CHAN_W];
      pixel_ch.blue           <= rgba[CHAN_W +: CHAN_W];
      pixel_ch.alpha          <= rgba[0 +: CHAN_W];
      @(posedge clock);
      while (!pixel_ch.ready)
         @(posedge clock);
      pixels_sent++;
      if (first)
         images_sent++;
      @(negedge clock);
   endtask

   // an image draws most pixels from a small color set, some of them near misses
   task automatic send_image();
      logic [COLOR_W-1:0] color_set [$];
      logic [COLOR_W-1:0] rgba;
      int                 set_size;
      int                 length;
      int                 pick;
      logic               first;
      set_size = $urandom_range(1, 22);
      for (int i = 0; i < set_size; i++) begin
         if (i > 0 && $urandom_range(99) < 30) begin
            rgba = color_set[$urandom_range(i - 1)];
            rgba[$urandom_range(COLOR_W - 1)] ^= 1'b1;
         end else begin
            rgba = $urandom;
         end
         if (rgba[CHAN_W-1:0] == '0)
            rgba[CHAN_W-1:0] = CHAN_W'($urandom_range(1, 255));
         color_set = {color_set, rgba};
      end
      length = $urandom_range(8, 64);
      first  = ($urandom_range(99) >= 10);
      for (int n = 0; n < length; n++) begin
         pick = $urandom_range(99);
         if (pick < 80)
            rgba = color_set[$urandom_range(set_size - 1)];
         else if (pick < 88)
            rgba = {24'($urandom), 8'h00};
         else
            rgba = $urandom;
         send_pixel(first, rgba);
         first = ($urandom_range(99) < 1);
      end
   endtask

   initial begin
      index_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_served != pressure_requests) begin
            pressure_served++;
            index_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            index_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin
      int guard;
      reset                   = 1'b1;
      pixel_ch.valid          = 1'b0;
      pixel_ch.first_of_image = 1'b0;
      pixel_ch.red            = '0;
      pixel_ch.green          = '0;
      pixel_ch.blue           = '0;
      pixel_ch.alpha          = '0;
      sender_idle_pct         = 34;
      receiver_idle_pct       = 60;
      pressure_requests       = 0;
      pressure_served         = 0;
      pixels_sent             = 0;
      images_sent             = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the palette, overflow it, hit both ends, transparent and clearing cases
      send_pixel(1'b1, 32'hFFFF_FFFF);
      send_pixel(1'b0, 32'h0000_0001);
      for (int k = 2; k < 16; k++)
         send_pixel(1'b0, {8'(k * 17), 8'hA5 ^ 8'(k), 8'(255 - k), 8'h80});
      send_pixel(1'b0, 32'h1234_5678);
      send_pixel(1'b0, 32'hFFFF_FFFF);
      send_pixel(1'b0, 32'hFFAA_F080);
      send_pixel(1'b0, 32'h0000_0000);
      send_pixel(1'b0, 32'hFFFF_FF00);
      send_pixel(1'b1, 32'hFFAA_F080);
      send_pixel(1'b0, 32'hFFAA_F081);
      send_pixel(1'b1, 32'h0000_0000);
      send_pixel(1'b0, 32'h0000_0001);

      while (pixels_sent < 600)
         send_image();
      sender_idle_pct   = 60;
      receiver_idle_pct = 34;
      while (pixels_sent < 1200)
         send_image();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      pressure_requests++;
      while (pixels_sent < 1800)
         send_image();
      pixel_ch.valid <= 1'b0;

      for (guard = 0; guard < DRAIN_LIMIT && pending_count != 0; guard++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_count != 0)
         $error("%0d response transactions never arrived", pending_count);
      $display("covered %0d pixels in %0d images under three idling mixes and one long stall",
               pixels_sent, images_sent);
      $display("palette hits %0d, new colors %0d, transparent %0d, overflow %0d",
               hit_count, new_count, transparent_count, overflow_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("unique_color_palette_indexer regression: pass");
      else
         $display("unique_color_palette_indexer regression: fail");
      $finish;
   end

endmodule
